// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl, all clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ptcr_pkg.sv -----
// ----------------------------------------------------------------------------
// ptcr_pkg
// Field widths shared by the page table / clock replacement block.
// ----------------------------------------------------------------------------
package ptcr_pkg;

  localparam int unsigned VaW      = 8;  // virtual address width
  localparam int unsigned PaW      = 6;  // physical address result width
  localparam int unsigned EvPageW  = 6;  // evicted page result width
  localparam int unsigned VpnSpan  = 256; // table span: every value of the VaW-bit va >> offset bits

endpackage

// ----- rtl/core/ptcr_ram.sv -----
// ----------------------------------------------------------------------------
// ptcr_ram
// Generic single write / single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/page_table_clock_replacement_top.sv -----
// ----------------------------------------------------------------------------
// page_table_clock_replacement_top
// Page table with second-chance (clock) frame replacement.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one virtual address per
// request. Output channel (out_valid_o / out_ready_i) returns one result per
// request: physical address, fault flag and the evicted page, if any.
// After reset the block runs a clearing pass over the page table and frame
// tables, max(NUM_PAGES, NUM_FRAMES) entries long; in_ready_o stays low
// until it ends.
// A hit goes through table read and reference update (StPtChk), then result
// load (StDone), which waits while the output register is still full.
// A fault adds a sweep step (StSwChk) for each frame the hand visits
// (between 1 and NUM_FRAMES + 1 visits, set by the reference bits), then
// the owner lookup (StOwn) and the table rewrites (StOwn, StMap). All
// lookups go through RAMs with one read port and one write port per table.
// The result sits in an output register; a new request is taken while it
// waits, but the block cannot finish that request until the register is
// drained by out_ready_i.
// ----------------------------------------------------------------------------
module page_table_clock_replacement_top
  import ptcr_pkg::*;
#(
  parameter int unsigned NUM_PAGES   = 64,
  parameter int unsigned NUM_FRAMES  = 16,
  parameter int unsigned OFFSET_BITS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VaW-1:0]     virtual_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PaW-1:0]     physical_address_o,
  output logic               page_fault_o,
  output logic               evicted_valid_o,
  output logic [EvPageW-1:0] evicted_page_o
);

  `include "assert_macros.svh"

  localparam int unsigned PW       = $clog2(NUM_PAGES);
  localparam int unsigned FW       = $clog2(NUM_FRAMES);
  localparam int unsigned ClrDepth = (NUM_PAGES > NUM_FRAMES) ? NUM_PAGES : NUM_FRAMES;
  localparam int unsigned CW       = $clog2(ClrDepth);
  localparam logic [VaW-1:0] OffMask = VaW'((32'd1 << OFFSET_BITS) - 32'd1);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StPtChk = 3'd2;
  localparam logic [2:0] StSwChk = 3'd3;
  localparam logic [2:0] StOwn   = 3'd4;
  localparam logic [2:0] StMap   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  // page number modulo table count, fixed at elaboration
  logic [PW-1:0] vpn_mod [VpnSpan];
  for (genvar g = 0; g < VpnSpan; g++) begin : g_vpn
    assign vpn_mod[g] = PW'(g % NUM_PAGES);
  end

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [FW-1:0] hand_q, hand_d, hand_nxt;
  logic          out_valid_q, out_valid_d;

  logic [PW-1:0]      page_q, page_d;
  logic [VaW-1:0]     offset_q, offset_d;
  logic [FW-1:0]      frame_q, frame_d;
  logic               fault_q, fault_d;
  logic               ev_valid_q, ev_valid_d;
  logic [PW-1:0]      ev_page_q, ev_page_d;
  logic [PaW-1:0]     pa_out_q, pa_out_d;
  logic               fault_out_q, fault_out_d;
  logic               ev_valid_out_q, ev_valid_out_d;
  logic [EvPageW-1:0] ev_page_out_q, ev_page_out_d;

  // page table: {valid, frame}
  logic          pt_we;
  logic [PW-1:0] pt_waddr, pt_raddr;
  logic [FW:0]   pt_wdata, pt_rdata;
  // reference bits
  logic          ref_we;
  logic [FW-1:0] ref_waddr, ref_raddr;
  logic          ref_wdata, ref_rdata;
  // frame owners: {owned, owner page}
  logic          own_we;
  logic [FW-1:0] own_waddr, own_raddr;
  logic [PW:0]   own_wdata, own_rdata;

  logic [VaW-1:0] vpn;
  logic [31:0]    pa_full;
  logic           accept;

  assign vpn      = VaW'(virtual_address_i >> OFFSET_BITS);
  assign hand_nxt = (hand_q == '0) ? FW'(NUM_FRAMES - 1) : hand_q - 1'b1;
  assign accept   = in_valid_i && in_ready_o;
  assign pa_full  = (32'(frame_q) << OFFSET_BITS) | 32'(offset_q);

  assign pt_raddr  = vpn_mod[vpn];
  assign ref_raddr = (state_q == StSwChk) ? hand_nxt : hand_q;
  assign own_raddr = hand_q;

  ptcr_ram #(.WIDTH(FW + 1), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  ptcr_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  ptcr_ram #(.WIDTH(PW + 1), .DEPTH(NUM_FRAMES)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    hand_d         = hand_q;
    out_valid_d    = out_valid_q;
    page_d         = page_q;
    offset_d       = offset_q;
    frame_d        = frame_q;
    fault_d        = fault_q;
    ev_valid_d     = ev_valid_q;
    ev_page_d      = ev_page_q;
    pa_out_d       = pa_out_q;
    fault_out_d    = fault_out_q;
    ev_valid_out_d = ev_valid_out_q;
    ev_page_out_d  = ev_page_out_q;
    in_ready_o     = 1'b0;
    pt_we          = 1'b0;
    pt_waddr       = page_q;
    pt_wdata       = {1'b1, frame_q};
    ref_we         = 1'b0;
    ref_waddr      = hand_q;
    ref_wdata      = 1'b1;
    own_we         = 1'b0;
    own_waddr      = frame_q;
    own_wdata      = {1'b1, page_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        pt_we     = 1'b1;
        pt_waddr  = clr_q[PW-1:0];
        pt_wdata  = '0;
        ref_we    = 32'(clr_q) < NUM_FRAMES;
        ref_waddr = clr_q[FW-1:0];
        ref_wdata = 1'b0;
        own_we    = 32'(clr_q) < NUM_FRAMES;
        own_waddr = clr_q[FW-1:0];
        own_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CW'(ClrDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          page_d     = pt_raddr;
          offset_d   = virtual_address_i & OffMask;
          fault_d    = 1'b0;
          ev_valid_d = 1'b0;
          ev_page_d  = '0;
          state_d    = StPtChk;
        end
      end
      StPtChk: begin
        if (pt_rdata[FW]) begin
          // hit: mark the frame referenced
          frame_d   = pt_rdata[FW-1:0];
          ref_we    = 1'b1;
          ref_waddr = pt_rdata[FW-1:0];
          ref_wdata = 1'b1;
          state_d   = StDone;
        end else begin
          // reference bit at the hand is being read this cycle
          fault_d = 1'b1;
          state_d = StSwChk;
        end
      end
      StSwChk: begin
        // clear a set bit and pass on, or claim a clear one
        ref_we    = 1'b1;
        ref_waddr = hand_q;
        ref_wdata = ~ref_rdata;
        hand_d    = hand_nxt;
        if (!ref_rdata) begin
          frame_d = hand_q;
          state_d = StOwn;
        end
      end
      StOwn: begin
        ev_valid_d = own_rdata[PW];
        ev_page_d  = own_rdata[PW] ? own_rdata[PW-1:0] : '0;
        if (own_rdata[PW]) begin
          pt_we    = 1'b1;
          pt_waddr = own_rdata[PW-1:0];
          pt_wdata = '0;
        end
        own_we  = 1'b1;
        state_d = StMap;
      end
      StMap: begin
        pt_we   = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          pa_out_d       = pa_full[PaW-1:0];
          fault_out_d    = fault_q;
          ev_valid_out_d = ev_valid_q;
          ev_page_out_d  = EvPageW'(ev_page_q);
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      hand_q      <= FW'(NUM_FRAMES - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hand_q      <= hand_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q         <= page_d;
    offset_q       <= offset_d;
    frame_q        <= frame_d;
    fault_q        <= fault_d;
    ev_valid_q     <= ev_valid_d;
    ev_page_q      <= ev_page_d;
    pa_out_q       <= pa_out_d;
    fault_out_q    <= fault_out_d;
    ev_valid_out_q <= ev_valid_out_d;
    ev_page_out_q  <= ev_page_out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = pa_out_q;
  assign page_fault_o       = fault_out_q;
  assign evicted_valid_o    = ev_valid_out_q;
  assign evicted_page_o     = ev_page_out_q;

  `PTCR_ASSERT_NOW(a_evict_needs_fault, out_valid_o && !page_fault_o,
                   !evicted_valid_o && (evicted_page_o == '0), "eviction reported on a hit")
  `PTCR_ASSERT_NEXT(a_accept_to_lookup, accept, state_q == StPtChk,
                    "accepted request did not start a table lookup")
  `PTCR_ASSERT_NEXT(a_hand_only_sweeps, state_q != StSwChk, $stable(hand_q),
                    "clock hand moved outside a sweep")

endmodule
